FILE: rtl/rpq_pkg.sv
// ----------------------------------------------------------------------------
// rpq_pkg: shared definitions for the retransmit packet queue
// Opcodes, status codes, register indexes and the stored entry layout.
// ----------------------------------------------------------------------------
package rpq_pkg;

   // request opcodes
   localparam logic [3:0] OP_APPEND     = 4'd0;
   localparam logic [3:0] OP_TAKE_FIRST = 4'd1;
   localparam logic [3:0] OP_TAKE_LAST  = 4'd2;
   localparam logic [3:0] OP_TAKE_AT    = 4'd3;
   localparam logic [3:0] OP_TOUCH      = 4'd4;
   localparam logic [3:0] OP_AGE        = 4'd5;
   localparam logic [3:0] OP_CAN_TX     = 4'd6;
   localparam logic [3:0] OP_FIND_SEQ   = 4'd7;
   localparam logic [3:0] OP_TICK       = 4'd8;

   // response status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_LIMIT     = 3'd1;
   localparam logic [2:0] ST_RANGE     = 3'd2;
   localparam logic [2:0] ST_NOT_DUE   = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_QUEUE_LIMIT = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT     = 2'd1;
   localparam logic [1:0] CSR_MAX_TRIES   = 2'd2;

   // reset values of the configuration registers
   localparam logic [4:0]  QUEUE_LIMIT_RST = 5'd16;
   localparam logic [15:0] TIMEOUT_RST     = 16'd100;
   localparam logic [7:0]  MAX_TRIES_RST   = 8'd3;

   // one queue entry as held in the entry memory
   typedef struct packed {
      logic [15:0] handle;
      logic [7:0]  seq;
      logic [31:0] stamp;
      logic [7:0]  retries;
   } entry_type;

endpackage

FILE: rtl/rpq_store.sv
// ----------------------------------------------------------------------------
// rpq_store: entry memory of the retransmit packet queue
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rpq_store
   import rpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
   input  entry_type                      wr_data,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
   output entry_type                      rd_data
);

   entry_type mem_ff [QUEUE_DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/retransmit_packet_queue.sv
// ----------------------------------------------------------------------------
// retransmit_packet_queue: ordered queue of packets awaiting acknowledgment
// Requests enter on the req_ stream, one response leaves on the rsp_ stream
// for every request, and registers are written through the csr_ channel.
//
// Each request runs under a small sequencer around one entry memory with a
// registered read port and one shared subtract/compare unit. req_tready is
// high only while the sequencer is idle. Append, tick, unused opcodes and
// rejected requests finish without a memory read; touch, age and transmit
// check read their entry once. Take shifts down every entry behind the taken
// one, and find visits entries up to the fill count, both at one entry per
// cycle through the read port. The next request is taken in the cycle after
// the response is registered, so a new request is accepted only once the
// previous one is finished. The response sits in an output register; a
// stalled receiver does not block acceptance of the next request, which
// then waits in its final state until the register frees up. Reset empties
// the queue, zeroes the millisecond counter and restores the register
// defaults; entry contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module retransmit_packet_queue
   import rpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode, packet_handle, seq_number, entry_index
   input  logic [31:0] req_tdata,
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status, out_handle, out_seq, age_ms, found_index, fill_level, zero pad
   output logic [71:0] rsp_tdata,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_EXEC  = 9'b000000010,
      S_TAKE  = 9'b000000100,
      S_SHIFT = 9'b000001000,
      S_TOUCH = 9'b000010000,
      S_AGE   = 9'b000100000,
      S_TX    = 9'b001000000,
      S_FIND  = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   state_type   state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [31:0] now_ff, now_in;
   logic [4:0]  limit_ff;
   logic [15:0] timeout_ff;
   logic [7:0]  max_tries_ff;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [3:0]  op_ff, op_in;
   logic [15:0] handle_ff, handle_in;
   logic [7:0]  seq_ff, seq_in;
   logic [3:0]  idx_ff, idx_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [2:0]  res_status_ff, res_status_in;
   logic [15:0] res_handle_ff, res_handle_in;
   logic [7:0]  res_seq_ff, res_seq_in;
   logic [31:0] res_age_ff, res_age_in;
   logic [3:0]  res_found_ff, res_found_in;
   logic [71:0] rsp_data_ff, rsp_data_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;

   logic [CMP_W-1:0] fill_ext;
   logic [CMP_W-1:0] idx_ext;
   logic [CMP_W-1:0] ptr_ext;
   logic [CNT_W-1:0] fill_dec;
   logic [IDX_W-1:0] idx_pos;
   logic [IDX_W-1:0] last_pos;
   logic [IDX_W-1:0] ptr_plus;
   logic [IDX_W-1:0] ptr_minus;
   logic             full;
   logic             idx_bad;
   logic             more;
   logic             accept;
   logic             out_free;
   logic [31:0]      age_diff;
   logic             due;
   logic [7:0]       retries_inc;
   logic             seq_hit;

   // entry memory
   rpq_store #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // handshakes
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // index and range helpers
   assign fill_ext  = CMP_W'(fill_ff);
   assign idx_ext   = CMP_W'(idx_ff);
   assign ptr_ext   = CMP_W'(ptr_ff);
   assign fill_dec  = fill_ff - CNT_W'(1);
   assign idx_pos   = idx_ext[IDX_W-1:0];
   assign last_pos  = fill_dec[IDX_W-1:0];
   assign ptr_plus  = ptr_ff + IDX_W'(1);
   assign ptr_minus = ptr_ff - IDX_W'(1);
   assign full      = (fill_ext >= CMP_W'(limit_ff)) || (fill_ext >= CMP_W'(QUEUE_DEPTH));
   assign idx_bad   = (idx_ext >= fill_ext);
   assign more      = ((ptr_ext + CMP_W'(1)) < fill_ext);

   // shared age subtract and compare unit
   assign age_diff    = now_ff - rd_data.stamp;
   assign due         = (rd_data.retries == 8'd0) || (age_diff > {16'd0, timeout_ff});
   assign retries_inc = (rd_data.retries == 8'hFF) ? rd_data.retries
                                                   : rd_data.retries + 8'd1;
   assign seq_hit     = (rd_data.seq == seq_ff);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      now_in        = now_ff;
      op_in         = op_ff;
      handle_in     = handle_ff;
      seq_in        = seq_ff;
      idx_in        = idx_ff;
      ptr_in        = ptr_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      res_seq_in    = res_seq_ff;
      res_age_in    = res_age_ff;
      res_found_in  = res_found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff;
      wr_data       = rd_data;
      rd_addr       = ptr_plus;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in         = req_tdata[3:0];
               handle_in     = req_tdata[19:4];
               seq_in        = req_tdata[27:20];
               idx_in        = req_tdata[31:28];
               res_status_in = ST_OK;
               res_handle_in = '0;
               res_seq_in    = '0;
               res_age_in    = '0;
               res_found_in  = '0;
               state_in      = S_EXEC;
            end
         end

         S_EXEC: begin
            state_in = S_DONE;
            unique case (op_ff)
               OP_APPEND: begin
                  if (full) begin
                     res_status_in = ST_LIMIT;
                  end else begin
                     wr_en           = 1'b1;
                     wr_addr         = fill_ff[IDX_W-1:0];
                     wr_data.handle  = handle_ff;
                     wr_data.seq     = seq_ff;
                     wr_data.stamp   = now_ff;
                     wr_data.retries = 8'd0;
                     fill_in         = fill_ff + CNT_W'(1);
                  end
               end
               OP_TAKE_FIRST, OP_TAKE_LAST, OP_TAKE_AT: begin
                  priority if (fill_ff == '0) begin
                     res_status_in = ST_LIMIT;
                  end else if (op_ff == OP_TAKE_AT && idx_bad) begin
                     res_status_in = ST_RANGE;
                  end else begin
                     priority if (op_ff == OP_TAKE_FIRST) begin
                        rd_addr = '0;
                     end else if (op_ff == OP_TAKE_LAST) begin
                        rd_addr = last_pos;
                     end else begin
                        rd_addr = idx_pos;
                     end
                     ptr_in   = rd_addr;
                     state_in = S_TAKE;
                  end
               end
               OP_TOUCH, OP_AGE, OP_CAN_TX: begin
                  if (idx_bad) begin
                     res_status_in = ST_RANGE;
                  end else begin
                     rd_addr = idx_pos;
                     priority if (op_ff == OP_TOUCH) begin
                        state_in = S_TOUCH;
                     end else if (op_ff == OP_AGE) begin
                        state_in = S_AGE;
                     end else begin
                        state_in = S_TX;
                     end
                  end
               end
               OP_FIND_SEQ: begin
                  if (fill_ff == '0) begin
                     res_status_in = ST_NOT_FOUND;
                  end else begin
                     rd_addr  = '0;
                     ptr_in   = '0;
                     state_in = S_FIND;
                  end
               end
               OP_TICK: begin
                  now_in = now_ff + 32'd1;
               end
               default: begin
               end
            endcase
         end

         // capture the taken entry, then pull later entries down
         S_TAKE: begin
            res_handle_in = rd_data.handle;
            res_seq_in    = rd_data.seq;
            if (more) begin
               rd_addr  = ptr_plus;
               ptr_in   = ptr_plus;
               state_in = S_SHIFT;
            end else begin
               fill_in  = fill_dec;
               state_in = S_DONE;
            end
         end

         // move one entry a cycle into the slot below it
         S_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = ptr_minus;
            wr_data = rd_data;
            if (more) begin
               rd_addr = ptr_plus;
               ptr_in  = ptr_plus;
            end else begin
               fill_in  = fill_dec;
               state_in = S_DONE;
            end
         end

         // restamp
         S_TOUCH: begin
            wr_en         = 1'b1;
            wr_addr       = idx_pos;
            wr_data.stamp = now_ff;
            state_in      = S_DONE;
         end

         S_AGE: begin
            res_age_in = age_diff;
            state_in   = S_DONE;
         end

         // transmit check with saturating retry count
         S_TX: begin
            if (due) begin
               wr_en           = 1'b1;
               wr_addr         = idx_pos;
               wr_data.retries = retries_inc;
               if (retries_inc <= max_tries_ff) begin
                  res_handle_in = rd_data.handle;
                  res_seq_in    = rd_data.seq;
               end else begin
                  res_status_in = ST_LIMIT;
               end
            end else begin
               res_status_in = ST_NOT_DUE;
            end
            state_in = S_DONE;
         end

         // linear search, one entry a cycle
         S_FIND: begin
            priority if (seq_hit) begin
               res_found_in = ptr_ext[3:0];
               state_in     = S_DONE;
            end else if (more) begin
               rd_addr = ptr_plus;
               ptr_in  = ptr_plus;
            end else begin
               res_status_in = ST_NOT_FOUND;
               state_in      = S_DONE;
            end
         end

         // hand the transaction to the output register
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, fill_ext[4:0], res_found_ff, res_age_ff,
                               res_seq_ff, res_handle_ff, res_status_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= QUEUE_LIMIT_RST;
         timeout_ff   <= TIMEOUT_RST;
         max_tries_ff <= MAX_TRIES_RST;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_QUEUE_LIMIT: limit_ff     <= csr_data[4:0];
               CSR_TIMEOUT:     timeout_ff   <= csr_data;
               CSR_MAX_TRIES:   max_tries_ff <= csr_data[7:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      handle_ff     <= handle_in;
      seq_ff        <= seq_in;
      idx_ff        <= idx_in;
      ptr_ff        <= ptr_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      res_seq_ff    <= res_seq_in;
      res_age_ff    <= res_age_in;
      res_found_ff  <= res_found_in;
      rsp_data_ff   <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // fill count never passes the memory depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(fill_ff) <= CMP_W'(QUEUE_DEPTH))
      else $error("fill count beyond queue depth");

   // fill count moves by at most one per transaction step
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (fill_ff != $past(fill_ff)) |->
         ((fill_ff == $past(fill_ff) + CNT_W'(1)) || (fill_ff + CNT_W'(1) == $past(fill_ff))))
      else $error("fill count jumped");

   // a response appears only out of the final state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside final state");

   // the millisecond counter moves only on a tick transaction
   a_tick_only: assert property (@(posedge clock) disable iff (reset)
      (now_ff != $past(now_ff)) |->
         (($past(state_ff) == S_EXEC) && ($past(op_ff) == OP_TICK)))
      else $error("time advanced without tick");
`endif

endmodule
